### src/gcvr_pkg.sv
// Package for the gated complex voltage recursion: defaults and register indexes.
`default_nettype none

package gcvr_pkg;

    // default voltage width and coefficient fraction bits (coefficient is Q2.COEF_FRAC)
    localparam int VOLT_WIDTH_DEF = 32;
    localparam int COEF_FRAC_DEF  = 16;

    // configuration register index width (leaves room for ignored indexes)
    localparam int CFG_INDEX_WIDTH = 3;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_COEF_RE = 3'd0,
        REG_COEF_IM = 3'd1,
        REG_INIT_RE = 3'd2,
        REG_INIT_IM = 3'd3
    } cfg_reg_t;

endpackage

`default_nettype wire

### src/gated_complex_voltage_recursion.sv
// Top level of the gated complex voltage recursion (cavity beam-loading tracker).
`default_nettype none

// Tracks a complex load voltage one bucket slot per beat. Each input beat is one bucket:
// the stored voltage (or init_re/init_im when restart is set) is multiplied by the
// complex coefficient coef_re + j*coef_im (Q2.COEF_FRAC), each part rounded to nearest
// (ties toward +inf) and saturated to VOLT_WIDTH bits. For a bunch that product is the
// seen voltage and the new state is product plus induced voltage, saturated; for an
// empty bucket seen is zero and the state is the product. Every input beat gives exactly
// one result beat, via the input register and then the result register. Throughput is
// one beat per clock while out_stall is low. The clock period is set by the state loop:
// four parallel coefficient-by-voltage products, the rounding add, and two saturations
// all sit between the voltage register and itself. Configuration writes take effect at
// the clock edge of cfg_wr_en and are meant to be made only while the block holds no beat.
module gated_complex_voltage_recursion #(
    parameter int VOLT_WIDTH = gcvr_pkg::VOLT_WIDTH_DEF,
    parameter int COEF_FRAC  = gcvr_pkg::COEF_FRAC_DEF,
    localparam int CW        = COEF_FRAC + 2,
    localparam int CFG_WIDTH = (VOLT_WIDTH > CW) ? VOLT_WIDTH : CW
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // configuration write port
    input  wire logic                                 cfg_wr_en,
    input  wire logic [gcvr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_WIDTH-1:0]                 cfg_data,
    // input channel
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 restart,
    input  wire logic                                 bunch,
    input  wire logic signed [VOLT_WIDTH-1:0]         induced_re,
    input  wire logic signed [VOLT_WIDTH-1:0]         induced_im,
    // output channel
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic                                      had_bunch,
    output logic signed [VOLT_WIDTH-1:0]              seen_re,
    output logic signed [VOLT_WIDTH-1:0]              seen_im,
    output logic signed [VOLT_WIDTH-1:0]              state_re,
    output logic signed [VOLT_WIDTH-1:0]              state_im
);

    localparam int VW = VOLT_WIDTH;
    localparam int PW = CW + VW;          // one exact product
    localparam int SW = PW + 2;           // sum of two products plus rounding half
    localparam int RW = SW - COEF_FRAC;   // rounded value before saturation
    localparam int AW = VW + 1;           // product plus induced voltage

    localparam logic signed [CW-1:0] COEF_ONE = CW'(1) << COEF_FRAC;
    localparam logic signed [SW-1:0] HALF     = SW'(1) << (COEF_FRAC - 1);
    localparam logic signed [VW-1:0] VMAX     = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN     = {1'b1, {(VW-1){1'b0}}};

    // configuration registers
    logic signed [CW-1:0] coef_re_reg;
    logic signed [CW-1:0] coef_im_reg;
    logic signed [VW-1:0] init_re_reg;
    logic signed [VW-1:0] init_im_reg;

    // load voltage state
    logic signed [VW-1:0] volt_re_reg;
    logic signed [VW-1:0] volt_im_reg;

    // input register
    logic                 s1_valid_reg;
    logic                 s1_restart_reg;
    logic                 s1_bunch_reg;
    logic signed [VW-1:0] s1_ind_re_reg;
    logic signed [VW-1:0] s1_ind_im_reg;

    // result register
    logic                 out_valid_reg;
    logic                 had_bunch_reg;
    logic signed [VW-1:0] seen_re_reg;
    logic signed [VW-1:0] seen_im_reg;
    logic signed [VW-1:0] state_re_reg;
    logic signed [VW-1:0] state_im_reg;

    // datapath nets
    logic                 out_free;
    logic                 s1_move;
    logic                 in_take;
    logic signed [VW-1:0] a_re;
    logic signed [VW-1:0] a_im;
    logic signed [PW-1:0] prod_rr;
    logic signed [PW-1:0] prod_ii;
    logic signed [PW-1:0] prod_ri;
    logic signed [PW-1:0] prod_ir;
    logic signed [SW-1:0] sum_re;
    logic signed [SW-1:0] sum_im;
    logic signed [RW-1:0] rnd_re;
    logic signed [RW-1:0] rnd_im;
    logic signed [VW-1:0] p_re;
    logic signed [VW-1:0] p_im;
    logic signed [AW-1:0] tot_re;
    logic signed [AW-1:0] tot_im;
    logic signed [VW-1:0] seen_re_next;
    logic signed [VW-1:0] seen_im_next;
    logic signed [VW-1:0] state_re_next;
    logic signed [VW-1:0] state_im_next;

    function automatic logic signed [VW-1:0] sat_rnd(input logic signed [RW-1:0] x);
        logic signed [VW-1:0] r;
        if (x > RW'(VMAX)) begin
            r = VMAX;
        end else if (x < RW'(VMIN)) begin
            r = VMIN;
        end else begin
            r = x[VW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [VW-1:0] sat_add(input logic signed [AW-1:0] x);
        logic signed [VW-1:0] r;
        if (x > AW'(VMAX)) begin
            r = VMAX;
        end else if (x < AW'(VMIN)) begin
            r = VMIN;
        end else begin
            r = x[VW-1:0];
        end
        return r;
    endfunction

    // handshake: the result register frees when empty or taken this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    // start voltage: init registers on restart, else the running state
    assign a_re = s1_restart_reg ? init_re_reg : volt_re_reg;
    assign a_im = s1_restart_reg ? init_im_reg : volt_im_reg;

    // four exact products, both parts from the old voltage
    assign prod_rr = PW'(coef_re_reg) * PW'(a_re);
    assign prod_ii = PW'(coef_im_reg) * PW'(a_im);
    assign prod_ri = PW'(coef_re_reg) * PW'(a_im);
    assign prod_ir = PW'(coef_im_reg) * PW'(a_re);

    // round to nearest, ties toward +inf, then drop the fraction bits
    assign sum_re = SW'(prod_rr) - SW'(prod_ii) + HALF;
    assign sum_im = SW'(prod_ri) + SW'(prod_ir) + HALF;
    assign rnd_re = sum_re[SW-1:COEF_FRAC];
    assign rnd_im = sum_im[SW-1:COEF_FRAC];
    assign p_re   = sat_rnd(rnd_re);
    assign p_im   = sat_rnd(rnd_im);

    // bunch adds its induced voltage; empty bucket passes the product
    assign tot_re = AW'(p_re) + AW'(s1_ind_re_reg);
    assign tot_im = AW'(p_im) + AW'(s1_ind_im_reg);

    assign seen_re_next  = s1_bunch_reg ? p_re : '0;
    assign seen_im_next  = s1_bunch_reg ? p_im : '0;
    assign state_re_next = s1_bunch_reg ? sat_add(tot_re) : p_re;
    assign state_im_next = s1_bunch_reg ? sat_add(tot_im) : p_im;

    // configuration registers: drop writes to unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_re_reg <= COEF_ONE;
            coef_im_reg <= '0;
            init_re_reg <= '0;
            init_im_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (gcvr_pkg::cfg_reg_t'(cfg_index))
                gcvr_pkg::REG_COEF_RE: coef_re_reg <= cfg_data[CW-1:0];
                gcvr_pkg::REG_COEF_IM: coef_im_reg <= cfg_data[CW-1:0];
                gcvr_pkg::REG_INIT_RE: init_re_reg <= cfg_data[VW-1:0];
                gcvr_pkg::REG_INIT_IM: init_im_reg <= cfg_data[VW-1:0];
                default: ;
            endcase
        end
    end

    // control: valid flags and the voltage state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            volt_re_reg   <= '0;
            volt_im_reg   <= '0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
                volt_re_reg   <= state_re_next;
                volt_im_reg   <= state_im_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: capture the input beat, then the result beat
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_restart_reg <= restart;
            s1_bunch_reg   <= bunch;
            s1_ind_re_reg  <= induced_re;
            s1_ind_im_reg  <= induced_im;
        end
        if (s1_move)
        begin
            had_bunch_reg <= s1_bunch_reg;
            seen_re_reg   <= seen_re_next;
            seen_im_reg   <= seen_im_next;
            state_re_reg  <= state_re_next;
            state_im_reg  <= state_im_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign had_bunch = had_bunch_reg;
    assign seen_re   = seen_re_reg;
    assign seen_im   = seen_im_reg;
    assign state_re  = state_re_reg;
    assign state_im  = state_im_reg;

    // the reported state is the stored state right after a beat moves on
    a_state_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> (volt_re_reg == state_re_reg) && (volt_im_reg == state_im_reg))
        else $error("result state differs from stored voltage");

    // an empty bucket reports no seen voltage
    a_empty_seen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move && !s1_bunch_reg |=> (seen_re_reg == '0) && (seen_im_reg == '0))
        else $error("empty bucket reported a seen voltage");

    // input is only held off while the input register is occupied
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with an empty input register");

    // a held beat reaches an empty result register on the next edge
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("beat did not advance into a free result register");

endmodule

`default_nettype wire

### tb/sv/gated_complex_voltage_recursion_test.sv
// Self-checking testbench for the gated complex voltage recursion: directed and random buckets.
`timescale 1ns / 100ps

module gated_complex_voltage_recursion_test;

    // Block geometry, taken from the package defaults the block is built with
    localparam int VW    = gcvr_pkg::VOLT_WIDTH_DEF;
    localparam int CF    = gcvr_pkg::COEF_FRAC_DEF;
    localparam int CW    = CF + 2;
    localparam int CFG_W = (VW > CW) ? VW : CW;
    localparam int IDX_W = gcvr_pkg::CFG_INDEX_WIDTH;

    // Register indexes past the last real register; writes to these must be dropped
    localparam logic [IDX_W-1:0] FIRST_UNUSED_INDEX = IDX_W'(int'(gcvr_pkg::REG_INIT_IM) + 1);
    localparam logic [IDX_W-1:0] LAST_UNUSED_INDEX  = {IDX_W{1'b1}};

    // Voltage and coefficient corner values
    localparam logic signed [VW-1:0] V_MAX  = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] V_MIN  = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [CW-1:0] C_MAX  = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN  = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] C_ONE  = CW'(1) << CF;
    localparam logic signed [CW-1:0] C_HALF = CW'(1) << (CF - 1);

    // Input register plus result register
    localparam int PIPE_LATENCY   = 2;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_BUCKETS = 1450;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic                 had;
        logic signed [VW-1:0] seen_re;
        logic signed [VW-1:0] seen_im;
        logic signed [VW-1:0] state_re;
        logic signed [VW-1:0] state_im;
    } bucket_result_t;

    // Stimulus and response wires; the stimulus side is known from time zero
    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 cfg_wr_en  = 1'b0;
    logic [IDX_W-1:0]     cfg_index  = gcvr_pkg::REG_COEF_RE;
    logic [CFG_W-1:0]     cfg_data   = '0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic                 restart    = 1'b0;
    logic                 bunch      = 1'b0;
    logic signed [VW-1:0] induced_re = '0;
    logic signed [VW-1:0] induced_im = '0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    logic                 had_bunch;
    logic signed [VW-1:0] seen_re;
    logic signed [VW-1:0] seen_im;
    logic signed [VW-1:0] state_re;
    logic signed [VW-1:0] state_im;

    // Our copy of the register file and of the tracked load voltage
    logic signed [CW-1:0] coef_re_set = C_ONE;
    logic signed [CW-1:0] coef_im_set = '0;
    logic signed [VW-1:0] init_re_set = '0;
    logic signed [VW-1:0] init_im_set = '0;
    logic signed [VW-1:0] track_re    = '0;
    logic signed [VW-1:0] track_im    = '0;

    // Results still owed by the block, oldest first
    bucket_result_t expected_buckets[$];

    int fault_count = 0;
    int cycle_count = 0;
    // When set, neither side idles: back-to-back beats
    bit quiet = 1'b0;

    gated_complex_voltage_recursion i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .restart    (restart),
        .bunch      (bunch),
        .induced_re (induced_re),
        .induced_im (induced_im),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .had_bunch  (had_bunch),
        .seen_re    (seen_re),
        .seen_im    (seen_im),
        .state_re   (state_re),
        .state_im   (state_im)
    );

    always #5 clk = ~clk;

    // Clamp an exact value into the signed voltage range
    function automatic logic signed [VW-1:0] clamp_volt(input longint x);
        if (x > longint'(V_MAX))
            return V_MAX;
        if (x < longint'(V_MIN))
            return V_MIN;
        return x[VW-1:0];
    endfunction

    // Add half an LSB, drop the fraction bits (ties go up), then clamp
    function automatic logic signed [VW-1:0] round_product(input longint acc);
        return clamp_volt((acc + (longint'(1) <<< (CF - 1))) >>> CF);
    endfunction

    // Advance the tracked voltage by one bucket and return the result it owes.
    // Both product parts use the voltage from before this bucket.
    function automatic bucket_result_t predict_bucket(input logic rs, input logic bn,
                                                      input logic signed [VW-1:0] add_re,
                                                      input logic signed [VW-1:0] add_im);
        logic signed [VW-1:0] base_re;
        logic signed [VW-1:0] base_im;
        logic signed [VW-1:0] prod_re;
        logic signed [VW-1:0] prod_im;
        bucket_result_t       r;
        base_re = rs ? init_re_set : track_re;
        base_im = rs ? init_im_set : track_im;
        prod_re = round_product(longint'(coef_re_set) * longint'(base_re)
                                - longint'(coef_im_set) * longint'(base_im));
        prod_im = round_product(longint'(coef_re_set) * longint'(base_im)
                                + longint'(coef_im_set) * longint'(base_re));
        r.had = bn;
        if (bn)
        begin
            r.seen_re = prod_re;
            r.seen_im = prod_im;
            track_re  = clamp_volt(longint'(prod_re) + longint'(add_re));
            track_im  = clamp_volt(longint'(prod_im) + longint'(add_im));
        end
        else
        begin
            // empty bucket: induced voltage plays no part
            r.seen_re = '0;
            r.seen_im = '0;
            track_re  = prod_re;
            track_im  = prod_im;
        end
        r.state_re = track_re;
        r.state_im = track_im;
        return r;
    endfunction

    // Idle length for one beat on either side
    function automatic int draw_wait();
        if (quiet)
            return 0;
        case ($urandom_range(3, 0))
            0, 1:    return 0;
            2:       return $urandom_range(3, 0);
            default: return $urandom_range(17, 0);
        endcase
    endfunction

    // Mostly decaying coefficients so the voltage does not pin at the rails
    function automatic logic signed [CW-1:0] pick_coef();
        case ($urandom_range(7, 0))
            0:       return C_MAX;
            1:       return C_MIN;
            2:       return '0;
            3:       return CW'($urandom);
            default: return CW'($urandom_range(2 * C_ONE, 0) - C_ONE);
        endcase
    endfunction

    function automatic logic signed [VW-1:0] pick_volt();
        case ($urandom_range(7, 0))
            0:       return V_MAX;
            1:       return V_MIN;
            2:       return '0;
            3:       return $urandom_range(2000, 0) - 1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic void report_fault(input string msg);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
            $display("%s", msg);
    endfunction

    function automatic void compare_field(input string field,
                                          input logic signed [VW-1:0] want,
                                          input logic signed [VW-1:0] got);
        if (got !== want)
            report_fault($sformatf("t=%0t %s: expected %0d (0x%h), got %0d (0x%h)",
                                   $time, field, want, want, got, got));
    endfunction

    // Register write; the write lands at the edge that samples cfg_wr_en, so update our copy there
    task automatic write_reg(input logic [IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        case (index)
            gcvr_pkg::REG_COEF_RE: coef_re_set = data[CW-1:0];
            gcvr_pkg::REG_COEF_IM: coef_im_set = data[CW-1:0];
            gcvr_pkg::REG_INIT_RE: init_re_set = data[VW-1:0];
            gcvr_pkg::REG_INIT_IM: init_im_set = data[VW-1:0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one bucket beat and hold it until taken. Valid is left high so a
    // zero gap gives back-to-back beats; settle_idle drops it.
    task automatic send_bucket(input logic rs, input logic bn,
                               input logic signed [VW-1:0] add_re,
                               input logic signed [VW-1:0] add_im);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        restart    <= rs;
        bunch      <= bn;
        induced_re <= add_re;
        induced_im <= add_im;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_buckets.push_back(predict_bucket(rs, bn, add_re, add_im));
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (expected_buckets.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    // Reset values: unit coefficient, zero start voltage, zero state.
    // Covers both saturation directions of the sum and an ignored induced voltage.
    task automatic test_power_on_state();
        send_bucket(1'b0, 1'b1, V_MAX, V_MIN);
        send_bucket(1'b0, 1'b1, V_MAX, V_MIN);
        send_bucket(1'b0, 1'b0, V_MIN, V_MAX);
        send_bucket(1'b1, 1'b0, '0, '0);
        send_bucket(1'b0, 1'b1, -1, 1);
        settle_idle();
    endtask

    // Coefficient and start voltage at their rails: product saturation
    task automatic test_coefficient_extremes();
        write_reg(gcvr_pkg::REG_COEF_RE, CFG_W'(C_MAX));
        write_reg(gcvr_pkg::REG_COEF_IM, CFG_W'(C_MIN));
        write_reg(gcvr_pkg::REG_INIT_RE, V_MAX);
        write_reg(gcvr_pkg::REG_INIT_IM, V_MIN);
        send_bucket(1'b1, 1'b1, V_MIN, V_MAX);
        send_bucket(1'b0, 1'b1, V_MAX, V_MAX);
        send_bucket(1'b0, 1'b0, V_MIN, V_MIN);
        settle_idle();
        write_reg(gcvr_pkg::REG_COEF_RE, CFG_W'(C_MIN));
        write_reg(gcvr_pkg::REG_COEF_IM, CFG_W'(C_MAX));
        send_bucket(1'b1, 1'b1, V_MAX, V_MAX);
        send_bucket(1'b1, 1'b0, '0, '0);
        send_bucket(1'b0, 1'b0, '0, '0);
        settle_idle();
    endtask

    // Exact half-LSB products: ties must round towards plus infinity
    task automatic test_rounding_ties();
        quiet = 1'b1;
        write_reg(gcvr_pkg::REG_COEF_RE, CFG_W'(C_HALF));
        write_reg(gcvr_pkg::REG_COEF_IM, '0);
        write_reg(gcvr_pkg::REG_INIT_RE, 1);
        write_reg(gcvr_pkg::REG_INIT_IM, -1);
        send_bucket(1'b1, 1'b0, '0, '0);
        settle_idle();
        write_reg(gcvr_pkg::REG_INIT_RE, 3);
        write_reg(gcvr_pkg::REG_INIT_IM, -3);
        send_bucket(1'b1, 1'b1, 1, -1);
        settle_idle();
        write_reg(gcvr_pkg::REG_COEF_RE, '0);
        write_reg(gcvr_pkg::REG_COEF_IM, CFG_W'(C_HALF));
        write_reg(gcvr_pkg::REG_INIT_RE, 1);
        write_reg(gcvr_pkg::REG_INIT_IM, -1);
        send_bucket(1'b1, 1'b1, '0, '0);
        send_bucket(1'b0, 1'b1, V_MAX, V_MIN);
        settle_idle();
        quiet = 1'b0;
    endtask

    // Writes to unused indexes are dropped; bits above a coefficient's width are ignored
    task automatic test_register_decode();
        for (int idx = FIRST_UNUSED_INDEX; idx <= LAST_UNUSED_INDEX; idx++)
            write_reg(IDX_W'(idx), $urandom);
        send_bucket(1'b1, 1'b1, 5, -5);
        send_bucket(1'b0, 1'b0, '0, '0);
        settle_idle();
        write_reg(gcvr_pkg::REG_COEF_RE, $urandom);
        write_reg(gcvr_pkg::REG_COEF_IM, $urandom);
        send_bucket(1'b1, 1'b1, $urandom, $urandom);
        send_bucket(1'b0, 1'b1, $urandom, $urandom);
        settle_idle();
    endtask

    // Runs of buckets under random settings: most runs open with a restart,
    // some carry on from the previous voltage, and restarts turn up mid-run.
    task automatic test_random_buckets(input int total);
        int   sent;
        int   run_len;
        logic rs;
        sent = 0;
        while (sent < total)
        begin
            settle_idle();
            quiet = ($urandom_range(3, 0) == 0);
            write_reg(gcvr_pkg::REG_COEF_RE, CFG_W'(pick_coef()));
            write_reg(gcvr_pkg::REG_COEF_IM, CFG_W'(pick_coef()));
            write_reg(gcvr_pkg::REG_INIT_RE, pick_volt());
            write_reg(gcvr_pkg::REG_INIT_IM, pick_volt());
            if ($urandom_range(3, 0) == 0)
                write_reg(IDX_W'($urandom_range(LAST_UNUSED_INDEX, FIRST_UNUSED_INDEX)),
                          $urandom);
            run_len = $urandom_range(160, 40);
            for (int k = 0; k < run_len && sent < total; k++)
            begin
                // flip idling now and then so gaps and bursts both occur mid-run
                if ($urandom_range(39, 0) == 0)
                    quiet = !quiet;
                rs = (k == 0) ? ($urandom_range(7, 0) != 0) : ($urandom_range(31, 0) == 0);
                send_bucket(rs, 1'($urandom_range(1, 0)), pick_volt(), pick_volt());
                sent++;
            end
        end
        settle_idle();
        quiet = 1'b0;
    endtask

    // Check each result beat against the oldest owed result
    always @(posedge clk)
    begin : result_check
        bucket_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_buckets.size() == 0)
                report_fault($sformatf("t=%0t result beat with nothing owed", $time));
            else
            begin
                want = expected_buckets.pop_front();
                compare_field("had_bunch", VW'(want.had), VW'(had_bunch));
                compare_field("seen_re", want.seen_re, seen_re);
                compare_field("seen_im", want.seen_im, seen_im);
                compare_field("state_re", want.state_re, state_re);
                compare_field("state_im", want.state_im, state_im);
            end
        end
    end

    // Hold off the result side for a random spell after each beat taken
    initial
    begin : result_stall
        int hold;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                hold = draw_wait();
                if (hold > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (hold) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // Watchdog: abandon a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("gated_complex_voltage_recursion_test: done, errors");
            $finish;
        end
    end

    // Sequence the tests
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_power_on_state();
        test_coefficient_extremes();
        test_rounding_ties();
        test_register_decode();
        test_random_buckets(RANDOM_BUCKETS);
        settle_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0 && expected_buckets.size() == 0)
            $display("gated_complex_voltage_recursion_test: done, clean");
        else
            $display("gated_complex_voltage_recursion_test: done, errors");
        $finish;
    end

endmodule

### filelist.f
src/gcvr_pkg.sv
src/gated_complex_voltage_recursion.sv
tb/sv/gated_complex_voltage_recursion_test.sv
